FILE: hw/rtl/lvr_pkg.sv
// ----------------------------------------------------------------------------
// lvr_pkg
// Shared types, codes and constant tables of the level transition ramp.
// ----------------------------------------------------------------------------
package lvr_pkg;

   // field widths
   localparam int LEVEL_W      = 16;
   localparam int AMOUNT_W     = 32;
   localparam int TTIME_W      = 8;
   localparam int DELAY_W      = 8;
   localparam int KIND_W       = 2;
   localparam int STEPS_W      = 8;
   localparam int TOTAL_W      = 26;
   localparam int DCOUNT_W     = 11;
   localparam int RES_W        = 20;
   localparam int STEP_MUL_W   = 13;
   localparam int RAW_STEPS_W  = 19;
   localparam int REQ_TDATA_W  = 64;
   localparam int RSP_TDATA_W  = 24;
   localparam int RSP_ACTIVE_BIT  = 16;
   localparam int RSP_CHANGED_BIT = 17;

   // serial divider: 32-bit dividend, two quotient bits per cycle
   localparam int DIV_W        = 32;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_ITERS    = DIV_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_ITERS);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

   // level limits and delay unit
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX     = 16'h7FFF;
   localparam logic [LEVEL_W-1:0]  LEVEL_MIN     = 16'h8000;
   localparam logic [DCOUNT_W-1:0] DELAY_UNIT_MS = 11'd5;
   localparam logic [STEPS_W-1:0]  MAX_STEPS_RST = 8'd10;

   // register map: index taken from paddr bit 2
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MAX_STEPS = 1'b0;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DELAY = 2'd1,
      PH_RAMP  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE       = 2'd0,
      CS_DIV_PERIOD = 2'd1,
      CS_DIV_DELTA  = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic iter;
      logic period_done;
      logic delta_done;
   } dp_cmd_type;

   typedef struct packed {
      logic start_item;
   } dp_status_type;

   // resolution of the transition time in ms
   function automatic logic [RES_W-1:0] res_ms(input logic [1:0] code);
      logic [RES_W-1:0] r;
      case (code)
         2'd0:    r = 20'd100;
         2'd1:    r = 20'd1000;
         2'd2:    r = 20'd10000;
         default: r = 20'd600000;
      endcase
      return r;
   endfunction

   // resolution divided by the 100 ms step length
   function automatic logic [STEP_MUL_W-1:0] step_mul(input logic [1:0] code);
      logic [STEP_MUL_W-1:0] r;
      case (code)
         2'd0:    r = 13'd1;
         2'd1:    r = 13'd10;
         2'd2:    r = 13'd100;
         default: r = 13'd6000;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/lvr_ctrl.sv
// ----------------------------------------------------------------------------
// lvr_ctrl
// Handshake and sequencing of the two divisions that follow a start word.
// ----------------------------------------------------------------------------
module lvr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  lvr_pkg::dp_status_type  status,
   output lvr_pkg::dp_cmd_type     cmd
);
   import lvr_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  cnt_last;

   assign cnt_last = (cnt_ff == DIV_CNT_W'(DIV_ITERS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept && status.start_item) state_in = CS_DIV_PERIOD;
         end
         CS_DIV_PERIOD: begin
            if (cnt_last) state_in = CS_DIV_DELTA;
         end
         CS_DIV_DELTA: begin
            if (cnt_last) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      req_tready      = (state_ff == CS_IDLE) && (!rsp_valid_ff || rsp_tready);
      accept          = req_tvalid && req_tready;
      cmd.accept      = accept;
      cmd.iter        = (state_ff == CS_DIV_PERIOD) || (state_ff == CS_DIV_DELTA);
      cmd.period_done = (state_ff == CS_DIV_PERIOD) && cnt_last;
      cmd.delta_done  = (state_ff == CS_DIV_DELTA) && cnt_last;
   end

   // iteration counter wraps between the two divisions
   assign cnt_in = cmd.iter ? cnt_ff + DIV_CNT_W'(1) : '0;

   // output word slot
   always_comb begin
      if (accept)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/lvr_dpath.sv
// ----------------------------------------------------------------------------
// lvr_dpath
// Ramp state, start setup, tick stepping, serial divider and output word.
// ----------------------------------------------------------------------------
module lvr_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  lvr_pkg::dp_cmd_type                 cmd,
   output lvr_pkg::dp_status_type              status,
   input  logic [lvr_pkg::KIND_W-1:0]          req_tuser,
   input  logic [lvr_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [lvr_pkg::STEPS_W-1:0]         max_steps,
   output logic [lvr_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import lvr_pkg::*;

   localparam int SUM_W = AMOUNT_W + 1;

   // input word fields
   logic [KIND_W-1:0]   kind;
   logic [LEVEL_W-1:0]  goal_level;
   logic [AMOUNT_W-1:0] step_amount;
   logic [TTIME_W-1:0]  transition_time;
   logic [DELAY_W-1:0]  start_delay;

   // ramp state
   logic [LEVEL_W-1:0]  cur_ff, cur_in;
   logic [LEVEL_W-1:0]  end_ff, end_in;
   logic [AMOUNT_W-1:0] delta_ff, delta_in;
   logic [STEPS_W-1:0]  sr_ff, sr_in;
   logic [TOTAL_W-1:0]  period_ff, period_in;
   logic [TOTAL_W-1:0]  pc_ff, pc_in;
   logic [DCOUNT_W-1:0] dc_ff, dc_in;
   phase_type           phase_ff, phase_in;
   logic                changed;

   // divider
   logic [STEPS_W-1:0]  div_rem_ff, div_rem_in, div_rem_next;
   logic [DIV_W-1:0]    div_quo_ff, div_quo_in, div_quo_next;
   logic [STEPS_W-1:0]  div_den_ff, div_den_in;
   logic [DIV_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;

   // start setup
   logic [TOTAL_W-1:0]     total;
   logic [RAW_STEPS_W-1:0] raw_steps;
   logic [STEPS_W-1:0]     steps;
   logic [STEPS_W-1:0]     divisor;
   logic [SUM_W-1:0]       diff;
   logic [SUM_W-1:0]       diff_abs;
   logic [DCOUNT_W-1:0]    dc_start;

   // step arithmetic
   logic [SUM_W-1:0]    sum;
   logic [LEVEL_W-1:0]  sat_level;

   logic                rsp_changed_ff;
   logic                rsp_active_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;

   assign kind            = req_tuser;
   assign goal_level      = req_tdata[15:0];
   assign step_amount     = req_tdata[47:16];
   assign transition_time = req_tdata[55:48];
   assign start_delay     = req_tdata[63:56];

   assign status.start_item = (kind == KIND_SET) || (kind == KIND_MOVE);

   // total time, step count and its divisor
   assign total     = TOTAL_W'(transition_time[5:0])
                    * TOTAL_W'(res_ms(transition_time[7:6]));
   assign raw_steps = RAW_STEPS_W'(transition_time[5:0])
                    * RAW_STEPS_W'(step_mul(transition_time[7:6]));
   assign steps     = (raw_steps > RAW_STEPS_W'(max_steps)) ? max_steps
                                                            : raw_steps[STEPS_W-1:0];
   assign divisor   = (steps == '0) ? STEPS_W'(1) : steps;
   assign dc_start  = DCOUNT_W'(start_delay) * DELAY_UNIT_MS;

   // signed amount to spread over the steps, split into sign and magnitude
   always_comb begin
      if (kind == KIND_SET)
         diff = {{(SUM_W-LEVEL_W){goal_level[LEVEL_W-1]}}, goal_level}
              - {{(SUM_W-LEVEL_W){cur_ff[LEVEL_W-1]}}, cur_ff};
      else
         diff = {step_amount[AMOUNT_W-1], step_amount};
      diff_abs = diff[SUM_W-1] ? (~diff + SUM_W'(1)) : diff;
   end

   // level plus step with 16-bit saturation
   always_comb begin
      sum = {{(SUM_W-LEVEL_W){cur_ff[LEVEL_W-1]}}, cur_ff}
          + {delta_ff[AMOUNT_W-1], delta_ff};
      if (!sum[SUM_W-1] && (|sum[SUM_W-2:LEVEL_W-1]))
         sat_level = LEVEL_MAX;
      else if (sum[SUM_W-1] && !(&sum[SUM_W-2:LEVEL_W-1]))
         sat_level = LEVEL_MIN;
      else
         sat_level = sum[LEVEL_W-1:0];
   end

   // restoring divider, two quotient bits per cycle
   always_comb begin
      logic [STEPS_W:0]   r;
      logic [DIV_W-1:0]   q;
      logic [STEPS_W-1:0] rem;
      rem = div_rem_ff;
      q   = div_quo_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         r = {rem, q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, div_den_ff}) begin
            r    = r - {1'b0, div_den_ff};
            q[0] = 1'b1;
         end
         rem = r[STEPS_W-1:0];
      end
      div_rem_next = rem;
      div_quo_next = q;
   end

   // divider registers
   always_comb begin
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      if (cmd.accept && status.start_item) begin
         div_rem_in = '0;
         div_quo_in = DIV_W'(total);
         div_den_in = divisor;
         mag_in     = diff_abs[DIV_W-1:0];
         neg_in     = diff[SUM_W-1];
      end else if (cmd.iter) begin
         if (cmd.period_done) begin
            div_rem_in = '0;
            div_quo_in = mag_ff;
         end else begin
            div_rem_in = div_rem_next;
            div_quo_in = div_quo_next;
         end
      end
   end

   // ramp state update for start and tick words
   always_comb begin
      logic step_en;
      cur_in    = cur_ff;
      end_in    = end_ff;
      delta_in  = delta_ff;
      sr_in     = sr_ff;
      period_in = period_ff;
      pc_in     = pc_ff;
      dc_in     = dc_ff;
      phase_in  = phase_ff;
      changed   = 1'b0;
      step_en   = 1'b0;

      if (cmd.accept && status.start_item) begin
         end_in   = goal_level;
         sr_in    = steps;
         dc_in    = dc_start;
         pc_in    = '0;
         phase_in = PH_DELAY;
      end else if (cmd.accept && (kind == KIND_TICK)) begin
         case (phase_ff)
            PH_DELAY: begin
               if (dc_ff != '0) dc_in = dc_ff - DCOUNT_W'(1);
               step_en = (dc_ff <= DCOUNT_W'(1));
            end
            PH_RAMP: begin
               if (pc_ff > TOTAL_W'(1)) begin
                  pc_in = pc_ff - TOTAL_W'(1);
               end else begin
                  pc_in   = '0;
                  step_en = 1'b1;
               end
            end
            default: step_en = 1'b0;
         endcase

         if (step_en) begin
            phase_in = PH_RAMP;
            pc_in    = period_ff;
            if (sr_ff != '0) begin
               sr_in = sr_ff - STEPS_W'(1);
               if (sat_level != cur_ff) begin
                  cur_in  = sat_level;
                  changed = 1'b1;
               end else begin
                  // stalled step abandons the ramp
                  phase_in = PH_IDLE;
               end
            end
            // last step snaps to the target
            if (sr_in == '0) begin
               if (cur_in != end_ff) changed = 1'b1;
               cur_in   = end_ff;
               phase_in = PH_IDLE;
            end
         end
      end

      if (cmd.period_done) period_in = div_quo_next[TOTAL_W-1:0];
      if (cmd.delta_done)
         delta_in = neg_ff ? (~div_quo_next + DIV_W'(1)) : div_quo_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         end_ff    <= '0;
         delta_ff  <= '0;
         sr_ff     <= '0;
         period_ff <= '0;
         pc_ff     <= '0;
         dc_ff     <= '0;
         phase_ff  <= PH_IDLE;
      end else begin
         cur_ff    <= cur_in;
         end_ff    <= end_in;
         delta_ff  <= delta_in;
         sr_ff     <= sr_in;
         period_ff <= period_in;
         pc_ff     <= pc_in;
         dc_ff     <= dc_in;
         phase_ff  <= phase_in;
      end
   end

   // divider and output word registers
   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      if (cmd.accept) begin
         rsp_level_ff   <= cur_in;
         rsp_active_ff  <= (phase_in != PH_IDLE);
         rsp_changed_ff <= changed;
      end
   end

   assign rsp_tdata = {(RSP_TDATA_W - RSP_CHANGED_BIT - 1)'(0),
                       rsp_changed_ff, rsp_active_ff, rsp_level_ff};

endmodule

FILE: hw/rtl/level_transition_ramp.sv
// ----------------------------------------------------------------------------
// level_transition_ramp
// Signed 16-bit level ramp driven by start words and 1 ms tick words.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one word per start (set-to-target or delta/move, kind in
//  req_tuser) or per 1 ms tick. rsp channel: exactly one word per req word,
//  holding the level, the active flag and the changed flag after that word.
//  csr port: APB register max_steps at byte address 0, read and write.
// Handshake and timing:
//  every word's result is loaded into the output register at the edge that
//  accepts it, so rsp_tvalid rises in the following cycle. A tick or an unused
//  kind leaves the controller idle. After a start's accept cycle the shared
//  divider, retiring two quotient bits a cycle, computes the step period and
//  then the per-step change; req_tready stays low meanwhile.
// Reset: level 0, no transition pending, max_steps 10, output register empty.
// Stall: a word is taken while the previous result waits in the output
//  register only if that result leaves in the same cycle; otherwise req_tready
//  stays low until rsp_tready takes it.
// ----------------------------------------------------------------------------
module level_transition_ramp (
   input  logic                              clock,
   input  logic                              reset,
   // tuser: kind[1:0]
   input  logic [lvr_pkg::KIND_W-1:0]        req_tuser,
   // tdata: goal_level[15:0], step_amount[47:16], transition_time[55:48],
   //        start_delay[63:56]
   input  logic [lvr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: level[15:0], active[16], changed[17], zero fill[23:18]
   output logic [lvr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lvr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import lvr_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [STEPS_W-1:0]  max_steps_ff, max_steps_in;
   logic                csr_wr;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_MAX_STEPS);
   assign max_steps_in = csr_wr ? csr_pwdata[STEPS_W-1:0] : max_steps_ff;
   assign csr_prdata   = (csr_paddr[2] == CSR_IDX_MAX_STEPS)
                         ? {(32 - STEPS_W)'(0), max_steps_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) max_steps_ff <= MAX_STEPS_RST;
      else       max_steps_ff <= max_steps_in;
   end

   lvr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lvr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .max_steps (max_steps_ff),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTHESIS
   // every accepted word leaves a result in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("no result after accepted word");

   // a start occupies the divider, so no word is taken next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_SET || req_tuser == KIND_MOVE))
      |=> !req_tready)
      else $error("word taken while divider busy");

   // a start always reports an active transition
   a_start_active: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == KIND_SET || req_tuser == KIND_MOVE))
      |=> rsp_tdata[RSP_ACTIVE_BIT])
      else $error("start not reported active");

   // only a tick can change the level
   a_changed_tick_only: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != KIND_TICK)
      |=> !rsp_tdata[RSP_CHANGED_BIT])
      else $error("level changed by a non-tick word");
`endif

endmodule

FILE: tb/level_transition_ramp_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_transition_ramp_tb
// Self-checking bench for the level transition ramp: a short table of corner
// words, then bursts of start words followed by 1 ms ticks, mostly until the
// ramp settles, with noisy starts and stray words, under several max_steps
// settings. Results are checked against typed table rows or a ramp predictor.
// ----------------------------------------------------------------------------
module level_transition_ramp_tb;
   import lvr_pkg::*;

   localparam int  LIMIT_CYCLES  = 1_000_000;
   localparam int  SETTLE_CYCLES = 40;
   localparam int  PHASE_WORDS   = 285;
   localparam int  NUM_ROWS      = 23;
   localparam logic [KIND_W-1:0]     KIND_UNUSED    = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] MAX_STEPS_ADDR = {CSR_IDX_MAX_STEPS, 2'b00};
   localparam longint LVL_TOP    = 32767;
   localparam longint LVL_BOTTOM = -32768;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               active;
      logic               changed;
   } ramp_out_type;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [LEVEL_W-1:0]  target;
      logic [AMOUNT_W-1:0] amount;
      logic [TTIME_W-1:0]  ttime;
      logic [DELAY_W-1:0]  dly;
      bit                  typed;
      logic [LEVEL_W-1:0]  e_level;
      bit                  e_active;
      bit                  e_changed;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [KIND_W-1:0]       req_tuser;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // predictor copy of the ramp state
   logic signed [LEVEL_W-1:0] lvl;
   logic signed [LEVEL_W-1:0] goal_lvl;
   longint                    step_delta;
   int unsigned               steps_left;
   int unsigned               period_ms;
   int unsigned               period_cnt;
   int unsigned               delay_cnt;
   phase_type                 ramp_phase;
   int unsigned               steps_cap;

   ramp_out_type level_q[$];
   int        err_count   = 0;
   int        useful_words = 0;
   int        burst_left  = 0;

   // receiver stall pattern
   int        stall_mode  = 0;
   int        stall_cnt   = 0;
   int        rx_cycle    = 0;

   dir_row_type directed_rows [NUM_ROWS] = '{
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1, 16'h0000, 0, 0},
      '{KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, 16'h0000, 0, 0},
      '{KIND_SET,    16'h7FFF, 32'h0000_0000, 8'h00, 8'h00, 1, 16'h0000, 1, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1, 16'h7FFF, 0, 1},
      '{KIND_MOVE,   16'h8000, 32'h8000_0000, 8'h01, 8'h00, 1, 16'h7FFF, 1, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1, 16'h8000, 0, 1},
      '{KIND_SET,    16'h8001, 32'h0000_0000, 8'h02, 8'h00, 1, 16'h8000, 1, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 1, 16'h8000, 0, 0},
      '{KIND_MOVE,   16'h0000, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_SET,    16'h1234, 32'h0000_0000, 8'h41, 8'h01, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_UNUSED, 16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_MOVE,   16'h7FFF, 32'h0000_0000, 8'h81, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_SET,    16'h0000, 32'h0000_0000, 8'h3F, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0},
      '{KIND_TICK,   16'h0000, 32'h0000_0000, 8'h00, 8'h00, 0, 16'h0000, 0, 0}
   };

   level_transition_ramp uut (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // ramp predictor
   // ------------------------------------------------------------------------
   function automatic void ramp_start(input logic [KIND_W-1:0] kind,
                                      input logic signed [LEVEL_W-1:0] target,
                                      input logic signed [AMOUNT_W-1:0] amount,
                                      input logic [TTIME_W-1:0] ttime,
                                      input logic [DELAY_W-1:0] dly);
      int unsigned res;
      int unsigned total;
      int unsigned steps;
      longint      divisor;
      case (ttime[7:6])
         2'd0:    res = 100;
         2'd1:    res = 1000;
         2'd2:    res = 10000;
         default: res = 600000;
      endcase
      total = ttime[5:0] * res;
      steps = total / 100;
      if (steps > steps_cap) steps = steps_cap;
      period_ms = (steps != 0) ? total / steps : total;
      divisor = (steps != 0) ? longint'(steps) : 64'sd1;
      goal_lvl = target;
      // set mode measures from where the level is now
      if (kind == KIND_SET) step_delta = (longint'(target) - longint'(lvl)) / divisor;
      else step_delta = longint'(amount) / divisor;
      steps_left = steps;
      delay_cnt  = 5 * dly;
      period_cnt = 0;
      ramp_phase = PH_DELAY;
   endfunction

   function automatic bit ramp_step();
      longint nxt;
      bit     chg;
      chg = 1'b0;
      ramp_phase = PH_RAMP;
      period_cnt = period_ms;
      if (steps_left != 0) begin
         nxt = longint'(lvl) + step_delta;
         steps_left--;
         if (nxt > LVL_TOP) nxt = LVL_TOP;
         else if (nxt < LVL_BOTTOM) nxt = LVL_BOTTOM;
         // a step that does not move the level abandons the ramp
         if (nxt != longint'(lvl)) begin
            lvl = nxt[LEVEL_W-1:0];
            chg = 1'b1;
         end else begin
            ramp_phase = PH_IDLE;
         end
      end
      // out of steps: snap to the target
      if (steps_left == 0) begin
         if (lvl != goal_lvl) chg = 1'b1;
         lvl = goal_lvl;
         ramp_phase = PH_IDLE;
      end
      return chg;
   endfunction

   function automatic bit ramp_tick();
      if (ramp_phase == PH_DELAY) begin
         if (delay_cnt != 0) begin
            delay_cnt--;
            if (delay_cnt != 0) return 1'b0;
         end
         return ramp_step();
      end
      if (ramp_phase == PH_RAMP) begin
         if (period_cnt > 1) begin
            period_cnt--;
            return 1'b0;
         end
         period_cnt = 0;
         return ramp_step();
      end
      return 1'b0;
   endfunction

   function automatic ramp_out_type predict_word(input logic [KIND_W-1:0] kind,
                                                 input logic [REQ_TDATA_W-1:0] data);
      ramp_out_type o;
      bit        chg;
      chg = 1'b0;
      if (kind == KIND_SET || kind == KIND_MOVE)
         ramp_start(kind, data[15:0], data[47:16], data[55:48], data[63:56]);
      else if (kind == KIND_TICK)
         chg = ramp_tick();
      o.level   = lvl;
      o.active  = (ramp_phase != PH_IDLE);
      o.changed = chg;
      return o;
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] pack_req(input logic [LEVEL_W-1:0] target,
                                                       input logic [AMOUNT_W-1:0] amount,
                                                       input logic [TTIME_W-1:0] ttime,
                                                       input logic [DELAY_W-1:0] dly);
      return {dly, ttime, amount, target};
   endfunction

   // ------------------------------------------------------------------------
   // sender: bursts with random gaps, one word per call
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [KIND_W-1:0] kind,
                            input logic [REQ_TDATA_W-1:0] data,
                            input bit has_typed = 1'b0,
                            input ramp_out_type typed_out = '0);
      ramp_out_type pred;
      int        gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (kind == KIND_SET || kind == KIND_MOVE || (kind == KIND_TICK && ramp_phase != PH_IDLE))
         useful_words++;
      req_tuser  <= kind;
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pred = predict_word(kind, data);
      level_q.push_back(has_typed ? typed_out : pred);
   endtask

   // hold the sender until every result word is back
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (level_q.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // write max_steps, then read it back in a back-to-back transfer
   task automatic set_max_steps(input logic [STEPS_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_STEPS_ADDR;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      steps_cap = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[STEPS_W-1:0] !== value) begin
         $error("max_steps: expected %0d, got %0d", value, csr_prdata[STEPS_W-1:0]);
         err_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // receiver: stall pattern redraws its mode and the mode's length in cycles
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_cnt  <= 0;
         stall_mode <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_cnt  <= $urandom_range(20, 200);
         end else begin
            stall_cnt <= stall_cnt - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ((rx_cycle % 7) < 3);
         endcase
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      ramp_out_type exp_out;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (level_q.size() == 0) begin
            $error("unexpected word: level %0d active %0b changed %0b",
                   $signed(rsp_tdata[15:0]), rsp_tdata[RSP_ACTIVE_BIT],
                   rsp_tdata[RSP_CHANGED_BIT]);
            err_count++;
         end else begin
            exp_out = level_q.pop_front();
            if (rsp_tdata[15:0] !== exp_out.level) begin
               $error("level: expected %0d, got %0d",
                      $signed(exp_out.level), $signed(rsp_tdata[15:0]));
               err_count++;
            end
            if (rsp_tdata[RSP_ACTIVE_BIT] !== exp_out.active) begin
               $error("active: expected %0b, got %0b",
                      exp_out.active, rsp_tdata[RSP_ACTIVE_BIT]);
               err_count++;
            end
            if (rsp_tdata[RSP_CHANGED_BIT] !== exp_out.changed) begin
               $error("changed: expected %0b, got %0b",
                      exp_out.changed, rsp_tdata[RSP_CHANGED_BIT]);
               err_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned         cap_list [6];
      int                  phase_goal;
      int                  pick;
      int                  tick_cap;
      int                  n;
      bit                  do_start;
      logic [KIND_W-1:0]   kind;
      logic [LEVEL_W-1:0]  target;
      logic [AMOUNT_W-1:0] amount;
      logic [TTIME_W-1:0]  ttime;
      logic [DELAY_W-1:0]  dly;

      req_tuser   = KIND_TICK;
      req_tdata   = '0;
      req_tvalid  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      lvl        = '0;
      goal_lvl   = '0;
      step_delta = 0;
      steps_left = 0;
      period_ms  = 0;
      period_cnt = 0;
      delay_cnt  = 0;
      ramp_phase = PH_IDLE;
      steps_cap  = MAX_STEPS_RST;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner words at the reset setting of max_steps
      foreach (directed_rows[i])
         send_word(directed_rows[i].kind,
                   pack_req(directed_rows[i].target, directed_rows[i].amount,
                            directed_rows[i].ttime, directed_rows[i].dly),
                   directed_rows[i].typed,
                   {directed_rows[i].e_level, directed_rows[i].e_active,
                    directed_rows[i].e_changed});
      drain(SETTLE_CYCLES);

      cap_list = '{0, 1, 255, $urandom_range(2, 12), 10, $urandom_range(1, 255)};

      foreach (cap_list[ph]) begin
         set_max_steps(cap_list[ph][STEPS_W-1:0]);
         phase_goal = useful_words + PHASE_WORDS;
         while (useful_words < phase_goal) begin
            pick     = $urandom_range(0, 99);
            do_start = 1'b1;
            tick_cap = 0;
            kind     = $urandom_range(0, 1) ? KIND_MOVE : KIND_SET;
            amount   = $urandom;
            target   = $urandom;
            if (pick < 70) begin
               // short well-formed ramp, usually run to the end
               case ($urandom_range(0, 3))
                  0:       target = lvl + 16'($urandom_range(0, 16)) - 16'd8;
                  1:       target = $urandom_range(0, 1) ? LEVEL_MAX : LEVEL_MIN;
                  default: target = $urandom;
               endcase
               case ($urandom_range(0, 4))
                  0, 1:    amount = 32'($urandom_range(0, 600)) - 32'd300;
                  2:       amount = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                  default: amount = $urandom;
               endcase
               if ($urandom_range(0, 19) == 0)
                  ttime = {2'b01, 6'($urandom_range(0, 1))};
               else
                  ttime = {2'b00, 6'($urandom_range(0, 3))};
               dly      = $urandom_range(0, 3);
               tick_cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : 4000;
            end else if (pick < 85) begin
               // noisy start, soon replaced by the next one
               ttime    = $urandom;
               dly      = $urandom;
               tick_cap = $urandom_range(0, 12);
            end else if (pick < 95) begin
               // stray ticks and unused kinds
               do_start = 1'b0;
               repeat ($urandom_range(1, 5))
                  send_word($urandom_range(0, 1) ? KIND_UNUSED : KIND_TICK,
                            {$urandom, $urandom});
            end else begin
               do_start = 1'b0;
               drain(0);
            end
            if (do_start) begin
               send_word(kind, pack_req(target, amount, ttime, dly));
               n = 0;
               // the phase budget also bounds the last ramp
               while (ramp_phase != PH_IDLE && n < tick_cap
                      && useful_words < phase_goal) begin
                  send_word(KIND_TICK, {$urandom, $urandom});
                  n++;
               end
            end
         end
         drain(SETTLE_CYCLES);
      end

      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: level_transition_ramp.f
hw/rtl/lvr_pkg.sv
hw/rtl/lvr_ctrl.sv
hw/rtl/lvr_dpath.sv
hw/rtl/level_transition_ramp.sv
tb/level_transition_ramp_tb.sv
